// File: sv/pcc_pkg.sv
// shared constants, state encoding and control structs for the corridor checker
package pcc_pkg;

  localparam int MaxWaypoints = 64;
  localparam int IdxW         = $clog2(MaxWaypoints);

  typedef logic [IdxW-1:0] idx_t;

  localparam logic [33:0] DistMax  = 34'h3_ffff_ffff;
  localparam logic [34:0] JitterSq = 35'd2304;

  // func codes of an input transaction
  localparam logic [1:0] FuncLoad    = 2'd0;
  localparam logic [1:0] FuncTouch   = 2'd1;
  localparam logic [1:0] FuncSession = 2'd2;
  localparam logic [1:0] FuncSpare   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CfgTolerance = 2'd0;
  localparam logic [1:0] CfgCount     = 2'd1;

  typedef enum logic [14:0] {
    StIdle = 15'h0001,
    StJmul = 15'h0002,
    StJchk = 15'h0004,
    StLd1  = 15'h0008,
    StLd2  = 15'h0010,
    StDiff = 15'h0020,
    StMul  = 15'h0040,
    StSum  = 15'h0080,
    StTsel = 15'h0100,
    StDiv  = 15'h0200,
    StProj = 15'h0400,
    StQpt  = 15'h0800,
    StEmul = 15'h1000,
    StAcc  = 15'h2000,
    StFin  = 15'h4000
  } state_e;

  // datapath commands, one per controller step
  typedef struct packed {
    logic idle;
    logic jmul;
    logic jchk;
    logic ld1;
    logic ld2;
    logic diff;
    logic mul;
    logic sum;
    logic tsel;
    logic div;
    logic proj;
    logic qpt;
    logic emul;
    logic acc;
    logic fin;
  } cmd_t;

  // datapath status back to the controller
  typedef struct packed {
    logic touch_acc;
    logic jitter;
    logic few;
    logic need_div;
    logic div_last;
    logic last_seg;
  } sts_t;

endpackage

// File: sv/pcc_ctrl.sv
// sequencer for the jitter check and the per-segment distance walk
module pcc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pcc_pkg::sts_t sts_i,
  output pcc_pkg::cmd_t cmd_o
);

  pcc_pkg::state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pcc_pkg::StIdle: if (sts_i.touch_acc) state_d = pcc_pkg::StJmul;
      pcc_pkg::StJmul: state_d = pcc_pkg::StJchk;
      pcc_pkg::StJchk: begin
        if (sts_i.jitter) state_d = pcc_pkg::StIdle;
        else if (sts_i.few) state_d = pcc_pkg::StFin;
        else state_d = pcc_pkg::StLd1;
      end
      pcc_pkg::StLd1:  state_d = pcc_pkg::StLd2;
      pcc_pkg::StLd2:  state_d = pcc_pkg::StDiff;
      pcc_pkg::StDiff: state_d = pcc_pkg::StMul;
      pcc_pkg::StMul:  state_d = pcc_pkg::StSum;
      pcc_pkg::StSum:  state_d = pcc_pkg::StTsel;
      pcc_pkg::StTsel: state_d = sts_i.need_div ? pcc_pkg::StDiv : pcc_pkg::StProj;
      pcc_pkg::StDiv:  if (sts_i.div_last) state_d = pcc_pkg::StProj;
      pcc_pkg::StProj: state_d = pcc_pkg::StQpt;
      pcc_pkg::StQpt:  state_d = pcc_pkg::StEmul;
      pcc_pkg::StEmul: state_d = pcc_pkg::StAcc;
      pcc_pkg::StAcc:  state_d = sts_i.last_seg ? pcc_pkg::StFin : pcc_pkg::StLd2;
      pcc_pkg::StFin:  state_d = pcc_pkg::StIdle;
      default:         state_d = pcc_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcc_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // command decode
  always_comb begin
    cmd_o      = '0;
    cmd_o.idle = (state_q == pcc_pkg::StIdle);
    cmd_o.jmul = (state_q == pcc_pkg::StJmul);
    cmd_o.jchk = (state_q == pcc_pkg::StJchk);
    cmd_o.ld1  = (state_q == pcc_pkg::StLd1);
    cmd_o.ld2  = (state_q == pcc_pkg::StLd2);
    cmd_o.diff = (state_q == pcc_pkg::StDiff);
    cmd_o.mul  = (state_q == pcc_pkg::StMul);
    cmd_o.sum  = (state_q == pcc_pkg::StSum);
    cmd_o.tsel = (state_q == pcc_pkg::StTsel);
    cmd_o.div  = (state_q == pcc_pkg::StDiv);
    cmd_o.proj = (state_q == pcc_pkg::StProj);
    cmd_o.qpt  = (state_q == pcc_pkg::StQpt);
    cmd_o.emul = (state_q == pcc_pkg::StEmul);
    cmd_o.acc  = (state_q == pcc_pkg::StAcc);
    cmd_o.fin  = (state_q == pcc_pkg::StFin);
  end

endmodule

// File: sv/pcc_dp.sv
// waypoint table, segment distance arithmetic, config and result registers
module pcc_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pcc_pkg::cmd_t cmd_i,
  output pcc_pkg::sts_t sts_o,
  input  logic          in_valid_i,
  input  logic [1:0]    in_func_i,
  input  logic [5:0]    in_slot_i,
  input  logic [15:0]   in_pos_x_i,
  input  logic [15:0]   in_pos_y_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          out_recorded_o,
  output logic          out_within_res_o,
  output logic [33:0]   out_dist_sq_o,
  input  logic          cfg_valid_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i
);

  logic [31:0] mem [pcc_pkg::MaxWaypoints];
  logic [31:0] rd_q;
  pcc_pkg::idx_t rd_addr;

  logic [15:0] tol_q;
  logic [6:0]  cnt_q;
  logic [6:0]  n;
  logic [15:0] px_q, py_q, lastx_q, lasty_q;
  logic        last_valid_q;
  logic [33:0] jsq0_q, jsq1_q;
  logic [31:0] p1_q, p2_q;
  logic signed [16:0] dx_q, dy_q, wx_q, wy_q;
  logic signed [33:0] m0_q, m1_q, m2_q, m3_q;
  logic [33:0] len2_q;
  logic signed [34:0] dot_q;
  logic [16:0] t_q;
  logic [34:0] rem_q;
  logic [3:0]  dcnt_q;
  logic signed [34:0] mx_q, my_q;
  logic signed [16:0] ex_q, ey_q;
  logic [33:0] e0_q, e1_q;
  logic [33:0] best_q;
  pcc_pkg::idx_t seg_q;
  logic        out_valid_q, rec_q, win_q;
  logic [33:0] dist_q;

  logic        out_free, acc_item;
  logic signed [16:0] jx, jy;
  logic signed [33:0] jsq0, jsq1, pm0, pm1, pm2, pm3, pe0, pe1;
  logic signed [34:0] pmx, pmy, rx, ry;
  logic signed [18:0] qx, qy, exx, eyy;
  logic [34:0] jsum, rem2;
  logic        ge;
  logic [33:0] dsum;
  logic [31:0] tol2;

  // input handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !(cmd_i.idle && out_free);
  assign acc_item   = in_valid_i && !in_stall_o;

  assign n = (cnt_q > 7'(pcc_pkg::MaxWaypoints)) ? 7'(pcc_pkg::MaxWaypoints) : cnt_q;

  // combinational arithmetic
  assign jx   = $signed({1'b0, px_q}) - $signed({1'b0, lastx_q});
  assign jy   = $signed({1'b0, py_q}) - $signed({1'b0, lasty_q});
  assign jsq0 = 34'(jx) * 34'(jx);
  assign jsq1 = 34'(jy) * 34'(jy);
  assign jsum = {1'b0, jsq0_q} + {1'b0, jsq1_q};
  assign pm0  = 34'(dx_q) * 34'(dx_q);
  assign pm1  = 34'(dy_q) * 34'(dy_q);
  assign pm2  = 34'(wx_q) * 34'(dx_q);
  assign pm3  = 34'(wy_q) * 34'(dy_q);
  assign rem2 = {rem_q[33:0], 1'b0};
  assign ge   = rem2 >= {1'b0, len2_q};
  assign pmx  = 35'($signed({1'b0, t_q})) * 35'(dx_q);
  assign pmy  = 35'($signed({1'b0, t_q})) * 35'(dy_q);
  assign rx   = mx_q + 35'sd32768;
  assign ry   = my_q + 35'sd32768;
  assign qx   = $signed({3'b000, p1_q[31:16]}) + rx[34:16];
  assign qy   = $signed({3'b000, p1_q[15:0]}) + ry[34:16];
  assign exx  = $signed({3'b000, px_q}) - qx;
  assign eyy  = $signed({3'b000, py_q}) - qy;
  assign pe0  = 34'(ex_q) * 34'(ex_q);
  assign pe1  = 34'(ey_q) * 34'(ey_q);
  assign dsum = e0_q + e1_q;
  assign tol2 = 32'(tol_q) * 32'(tol_q);

  // status
  assign sts_o.touch_acc = acc_item && (in_func_i == pcc_pkg::FuncTouch);
  assign sts_o.jitter    = last_valid_q && (jsum < pcc_pkg::JitterSq);
  assign sts_o.few       = n < 7'd2;
  assign sts_o.need_div  = (len2_q != '0) && (dot_q > 35'sd0) &&
                           (dot_q < $signed({1'b0, len2_q}));
  assign sts_o.div_last  = dcnt_q == 4'd15;
  assign sts_o.last_seg  = {1'b0, seg_q} == (n - 7'd2);

  // table read address
  always_comb begin
    rd_addr = '0;
    if (cmd_i.ld1) rd_addr = pcc_pkg::idx_t'(1);
    else if (cmd_i.acc) rd_addr = seg_q + pcc_pkg::idx_t'(2);
  end

  // waypoint table
  always_ff @(posedge clk_i) begin
    if (acc_item && in_func_i == pcc_pkg::FuncLoad &&
        {1'b0, in_slot_i} < 7'(pcc_pkg::MaxWaypoints)) begin
      mem[pcc_pkg::idx_t'(in_slot_i)] <= {in_pos_x_i, in_pos_y_i};
    end
    rd_q <= mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q        <= 16'd320;
      cnt_q        <= '0;
      last_valid_q <= 1'b0;
      lastx_q      <= '0;
      lasty_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_index_i == pcc_pkg::CfgTolerance) tol_q <= cfg_data_i;
      if (cfg_valid_i && cfg_index_i == pcc_pkg::CfgCount) cnt_q <= cfg_data_i[6:0];
      if (acc_item && in_func_i == pcc_pkg::FuncSession) last_valid_q <= 1'b0;
      if (cmd_i.jchk && !sts_o.jitter) begin
        last_valid_q <= 1'b1;
        lastx_q      <= px_q;
        lasty_q      <= py_q;
      end
      if ((acc_item && in_func_i != pcc_pkg::FuncTouch) ||
          (cmd_i.jchk && sts_o.jitter) || cmd_i.fin) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // arithmetic and result payload
  always_ff @(posedge clk_i) begin
    if (acc_item) begin
      px_q <= in_pos_x_i;
      py_q <= in_pos_y_i;
      if (in_func_i != pcc_pkg::FuncTouch) begin
        rec_q  <= 1'b0;
        win_q  <= 1'b0;
        dist_q <= '0;
      end
    end
    if (cmd_i.jmul) begin
      jsq0_q <= jsq0;
      jsq1_q <= jsq1;
    end
    if (cmd_i.jchk) begin
      best_q <= (n == 7'd0) ? '0 : pcc_pkg::DistMax;
      seg_q  <= '0;
      if (sts_o.jitter) begin
        rec_q  <= 1'b0;
        win_q  <= 1'b1;
        dist_q <= '0;
      end
    end
    if (cmd_i.ld1) p1_q <= rd_q;
    if (cmd_i.ld2) p2_q <= rd_q;
    if (cmd_i.diff) begin
      dx_q <= $signed({1'b0, p2_q[31:16]}) - $signed({1'b0, p1_q[31:16]});
      dy_q <= $signed({1'b0, p2_q[15:0]}) - $signed({1'b0, p1_q[15:0]});
      wx_q <= $signed({1'b0, px_q}) - $signed({1'b0, p1_q[31:16]});
      wy_q <= $signed({1'b0, py_q}) - $signed({1'b0, p1_q[15:0]});
    end
    if (cmd_i.mul) begin
      m0_q <= pm0;
      m1_q <= pm1;
      m2_q <= pm2;
      m3_q <= pm3;
    end
    if (cmd_i.sum) begin
      len2_q <= m0_q[33:0] + m1_q[33:0];
      dot_q  <= 35'(m2_q) + 35'(m3_q);
    end
    // projection parameter selection
    if (cmd_i.tsel) begin
      dcnt_q <= '0;
      rem_q  <= dot_q;
      if (sts_o.need_div || len2_q == '0 || dot_q <= 35'sd0) t_q <= '0;
      else t_q <= 17'h10000;
    end
    // restoring division, one quotient bit a cycle
    if (cmd_i.div) begin
      rem_q  <= ge ? rem2 - {1'b0, len2_q} : rem2;
      t_q    <= {t_q[15:0], ge};
      dcnt_q <= dcnt_q + 4'd1;
    end
    if (cmd_i.proj) begin
      mx_q <= pmx;
      my_q <= pmy;
    end
    if (cmd_i.qpt) begin
      ex_q <= exx[16:0];
      ey_q <= eyy[16:0];
    end
    if (cmd_i.emul) begin
      e0_q <= pe0;
      e1_q <= pe1;
    end
    // running minimum and move to next segment
    if (cmd_i.acc) begin
      if (dsum < best_q) best_q <= dsum;
      seg_q <= seg_q + pcc_pkg::idx_t'(1);
      p1_q  <= p2_q;
    end
    if (cmd_i.fin) begin
      rec_q  <= 1'b1;
      win_q  <= best_q <= {2'b00, tol2};
      dist_q <= best_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_recorded_o   = rec_q;
  assign out_within_res_o = win_q;
  assign out_dist_sq_o    = dist_q;

endmodule

// File: sv/polyline_corridor_check.sv
// top level of the touch-sample corridor checker
// Each input transaction gives one result transaction. Waypoint loads and session
// restarts are answered once taken, dropped jitter samples from the jitter check. A
// recorded touch sample walks the polyline one segment at a time through one
// shared datapath: setup, then per segment load, difference, multiply, sum, select
// the projection parameter (via the bit-serial divider where needed), project,
// square the error and update the running minimum. Only one transaction is in
// flight; a new one is taken once the output register is empty or its result is
// leaving it. Config writes are always ready and must be made while idle.
module polyline_corridor_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  in_func_i,
  input  logic [5:0]  in_slot_i,
  input  logic [15:0] in_pos_x_i,
  input  logic [15:0] in_pos_y_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        out_recorded_o,
  output logic        out_within_res_o,
  output logic [33:0] out_dist_sq_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  pcc_pkg::cmd_t cmd;
  pcc_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  // sequencer
  pcc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // datapath
  pcc_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .in_valid_i       (in_valid_i),
    .in_func_i        (in_func_i),
    .in_slot_i        (in_slot_i),
    .in_pos_x_i       (in_pos_x_i),
    .in_pos_y_i       (in_pos_y_i),
    .in_stall_o       (in_stall_o),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_recorded_o   (out_recorded_o),
    .out_within_res_o (out_within_res_o),
    .out_dist_sq_o    (out_dist_sq_o),
    .cfg_valid_i      (cfg_valid_i & cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

`ifndef SYNTH
  // a result not recorded never carries a distance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_recorded_o |-> out_dist_sq_o == 34'd0)
    else $error("unrecorded result with nonzero distance");

  // no new transaction while a result is stuck in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !(out_valid_o && out_stall_i))
    else $error("input taken while output blocked");

  // a touch transaction always moves the sequencer out of idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_func_i == pcc_pkg::FuncTouch |=> in_stall_o)
    else $error("touch transaction did not start the walk");
`endif

endmodule
